// ----- hdl/tte_pkg.sv -----
// ============================================================================
// tte_pkg - shared types and codes for the text terminal cursor engine
// Command/result codes, cursor and sequencer types, character constants.
// ============================================================================
package tte_pkg;

   // field widths fixed by the stream formats
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int CHAR_W  = 8;
   localparam int COLOR_W = 4;

   // default screen geometry
   localparam int DEF_COLUMNS = 80;
   localparam int DEF_ROWS    = 25;

   // command opcodes
   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_BACK  = 2'd1;
   localparam logic [1:0] OP_SET   = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   // configuration register indexes
   localparam logic CSR_FG = 1'b0;
   localparam logic CSR_BG = 1'b1;

   // reset colors
   localparam logic [COLOR_W-1:0] FG_RESET = 4'd15;
   localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

   // characters
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;

   // last tab_count value: a tab expands to four spaces
   localparam logic [1:0] TAB_LAST = 2'd3;

   typedef enum logic [1:0] {
      ACT_WRITE  = 2'd0,
      ACT_SCROLL = 2'd1,
      ACT_CURSOR = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   // one-hot sequencer phase
   typedef enum logic [3:0] {
      PH_WRITE  = 4'b0001,
      PH_SCROLL = 4'b0010,
      PH_MOVE   = 4'b0100,
      PH_FINAL  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [CHAR_W-1:0] char_code;
      logic [COL_W-1:0]  new_col;
      logic [ROW_W-1:0]  new_row;
   } cmd_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
   } cursor_type;

   typedef struct packed {
      phase_type  phase;
      logic [1:0] tab_count;
   } seq_type;

   localparam seq_type SEQ_START = '{phase: PH_WRITE, tab_count: 2'd0};

   // one step of work: the result it emits and the status of the command
   typedef struct packed {
      logic              emit;
      logic              done;
      action_type        action;
      logic [CHAR_W-1:0] cell_char;
      cursor_type        pos;
   } step_type;

endpackage

// ----- hdl/tte_step.sv -----
// ============================================================================
// tte_step - one sequencer step of the cursor engine
// Given the current command, cursor and phase, forms the next result item,
// the next cursor and the next phase.
// ============================================================================
module tte_step
   import tte_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  cmd_type    cmd,
   input  cursor_type cur,
   input  seq_type    seq,
   output step_type   step,
   output cursor_type cur_nxt,
   output seq_type    seq_nxt
);

   localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

   logic              is_tab;
   logic [CHAR_W-1:0] put_ch;

   assign is_tab = (cmd.char_code == CHAR_TAB);
   assign put_ch = is_tab ? CHAR_SPACE : cmd.char_code;

   always_comb begin
      step.emit      = 1'b1;
      step.done      = 1'b0;
      step.action    = ACT_CURSOR;
      step.cell_char = CHAR_NUL;
      step.pos       = cur;
      cur_nxt        = cur;
      seq_nxt        = seq;

      unique case (cmd.opcode)
         OP_PUT: begin
            unique case (seq.phase)
               PH_WRITE: begin
                  if (!is_tab && cmd.char_code == CHAR_NEWLINE) begin
                     cur_nxt.col = '0;
                     if (cur.row == LAST_ROW) begin
                        step.action    = ACT_SCROLL;
                        step.cell_char = CHAR_SPACE;
                        step.pos       = '0;
                        seq_nxt.phase  = PH_MOVE;
                     end else begin
                        cur_nxt.row = cur.row + 1'b1;
                        step.pos    = '{col: '0, row: cur.row + 1'b1};
                        step.done   = 1'b1;
                     end
                  end else begin
                     step.action    = ACT_WRITE;
                     step.cell_char = put_ch;
                     seq_nxt.phase  = PH_MOVE;
                     if (cur.col == LAST_COL) begin
                        cur_nxt.col = '0;
                        // wrap off the bottom row: row stays pinned, a scroll follows the write
                        if (cur.row == LAST_ROW) seq_nxt.phase = PH_SCROLL;
                        else cur_nxt.row = cur.row + 1'b1;
                     end else begin
                        cur_nxt.col = cur.col + 1'b1;
                     end
                  end
               end
               PH_SCROLL: begin
                  step.action    = ACT_SCROLL;
                  step.cell_char = CHAR_SPACE;
                  step.pos       = '0;
                  seq_nxt.phase  = PH_MOVE;
               end
               PH_MOVE: begin
                  if (is_tab) begin
                     if (seq.tab_count == TAB_LAST) begin
                        seq_nxt.phase = PH_FINAL;
                     end else begin
                        seq_nxt.tab_count = seq.tab_count + 1'b1;
                        seq_nxt.phase     = PH_WRITE;
                     end
                  end else begin
                     step.done = 1'b1;
                  end
               end
               PH_FINAL: begin
                  step.done = 1'b1;
               end
               default: begin
                  step.emit = 1'b0;
                  step.done = 1'b1;
               end
            endcase
         end
         OP_BACK: begin
            if (seq.phase == PH_MOVE) begin
               step.done = 1'b1;
            end else if (cur.col == '0 && cur.row == '0) begin
               // at the origin: nothing to do
               step.emit = 1'b0;
               step.done = 1'b1;
            end else begin
               if (cur.col == '0) begin
                  cur_nxt.col = LAST_COL;
                  cur_nxt.row = cur.row - 1'b1;
               end else begin
                  cur_nxt.col = cur.col - 1'b1;
               end
               step.action    = ACT_WRITE;
               step.cell_char = CHAR_SPACE;
               step.pos       = cur_nxt;
               seq_nxt.phase  = PH_MOVE;
            end
         end
         OP_SET: begin
            cur_nxt.col = (cmd.new_col > LAST_COL) ? LAST_COL : cmd.new_col;
            cur_nxt.row = (cmd.new_row > LAST_ROW) ? LAST_ROW : cmd.new_row;
            step.pos    = cur_nxt;
            step.done   = 1'b1;
         end
         OP_CLEAR: begin
            step.action    = ACT_CLEAR;
            step.cell_char = cmd.char_code;
            step.pos       = '0;
            step.done      = 1'b1;
         end
         default: begin
            step.emit = 1'b0;
            step.done = 1'b1;
         end
      endcase

      if (step.done) seq_nxt = SEQ_START;
   end

endmodule

// ----- hdl/text_terminal_cursor_engine.sv -----
// ============================================================================
// text_terminal_cursor_engine - text console cursor engine
// Takes put-char / backspace / set-cursor / clear commands and emits display
// actions (cell write, scroll, cursor move, clear), one a cycle unless stalled.
// ============================================================================
// Path: an accepted command is loaded into the command register, and each
//   result item into the result register; items come one per cycle while
//   rsp_tready is high, and a held item stalls the single step sequencer.
// Steps: a put char writes the cell (a newline does not), may scroll, then
//   moves the cursor; a tab does so four times. The next command is taken
//   in the cycle its last item is formed.
// Reset: synchronous; cursor to (0,0), fg 15, bg 0, no item pending.
// ============================================================================
module text_terminal_cursor_engine
   import tte_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS
) (
   input  logic                clock,
   input  logic                reset,

   // command stream
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [23:0]         req_tdata,   // char_code[7:0], new_col[14:8],
                                            // new_row[19:15], zero fill
   input  logic [1:0]          req_tuser,   // opcode[1:0]

   // result stream
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,   // cell_char[7:0], col[14:8],
                                            // row[19:15], fg[23:20],
                                            // bg[27:24], zero fill
   output logic [1:0]          rsp_tuser,   // action[1:0]
   output logic                rsp_tlast,   // last item of the command

   // configuration
   input  logic                csr_wen,
   input  logic                csr_index,
   input  logic [COLOR_W-1:0]  csr_wdata
);

   localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

   // command register and sequencer state
   logic        busy_ff, busy_in;
   cmd_type     cmd_ff, cmd_in;
   seq_type     seq_ff, seq_in;
   cursor_type  cursor_ff, cursor_in;

   // colors
   logic [COLOR_W-1:0] fg_ff, fg_in;
   logic [COLOR_W-1:0] bg_ff, bg_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   action_type         rsp_action_ff, rsp_action_in;
   logic [CHAR_W-1:0]  rsp_char_ff, rsp_char_in;
   cursor_type         rsp_pos_ff, rsp_pos_in;
   logic [COLOR_W-1:0] rsp_fg_ff, rsp_fg_in;
   logic [COLOR_W-1:0] rsp_bg_ff, rsp_bg_in;
   logic               rsp_last_ff, rsp_last_in;

   step_type    step;
   cursor_type  cur_nxt;
   seq_type     seq_nxt;

   logic out_free;
   logic fire;
   logic accept;

   tte_step #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_step (
      .cmd     (cmd_ff),
      .cur     (cursor_ff),
      .seq     (seq_ff),
      .step    (step),
      .cur_nxt (cur_nxt),
      .seq_nxt (seq_nxt)
   );

   // result slot is free when empty or being drained this cycle
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = busy_ff && out_free;
   // take a new command when idle or when the current one finishes now
   assign req_tready = !busy_ff || (fire && step.done);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      busy_in   = busy_ff;
      cmd_in    = cmd_ff;
      seq_in    = seq_ff;
      cursor_in = cursor_ff;

      if (fire) begin
         seq_in    = seq_nxt;
         cursor_in = cur_nxt;
         if (step.done) busy_in = 1'b0;
      end
      if (accept) begin
         busy_in = 1'b1;
         cmd_in  = '{opcode:    req_tuser,
                     char_code: req_tdata[7:0],
                     new_col:   req_tdata[14:8],
                     new_row:   req_tdata[19:15]};
      end
   end

   // configuration writes
   always_comb begin
      fg_in = fg_ff;
      bg_in = bg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_FG:  fg_in = csr_wdata;
            CSR_BG:  bg_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // result register: load on an emitting step, clear when taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_action_in = rsp_action_ff;
      rsp_char_in   = rsp_char_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_fg_in     = rsp_fg_ff;
      rsp_bg_in     = rsp_bg_ff;
      rsp_last_in   = rsp_last_ff;
      if (fire && step.emit) begin
         rsp_valid_in  = 1'b1;
         rsp_action_in = step.action;
         rsp_char_in   = step.cell_char;
         rsp_pos_in    = step.pos;
         rsp_fg_in     = fg_ff;
         rsp_bg_in     = bg_ff;
         rsp_last_in   = step.done;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         seq_ff       <= SEQ_START;
         cursor_ff    <= '0;
         fg_ff        <= FG_RESET;
         bg_ff        <= BG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         seq_ff       <= seq_in;
         cursor_ff    <= cursor_in;
         fg_ff        <= fg_in;
         bg_ff        <= bg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      rsp_action_ff <= rsp_action_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_fg_ff     <= rsp_fg_in;
      rsp_bg_ff     <= rsp_bg_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_action_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {4'd0, rsp_bg_ff, rsp_fg_ff,
                        rsp_pos_ff.row, rsp_pos_ff.col, rsp_char_ff};

   // ------------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------------

   // cursor never leaves the screen
   a_cursor_on_screen: assert property (@(posedge clock) disable iff (reset)
      cursor_ff.col <= LAST_COL && cursor_ff.row <= LAST_ROW)
      else $error("cursor outside screen");

   // an idle engine always restarts its sequence from the write phase
   a_idle_seq_start: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (seq_ff.phase == PH_WRITE && seq_ff.tab_count == 2'd0))
      else $error("sequencer not at start while idle");

   // scrolls are only produced with the cursor pinned to the bottom row
   a_scroll_at_bottom: assert property (@(posedge clock) disable iff (reset)
      (fire && step.emit && step.action == ACT_SCROLL) |-> cursor_ff.row == LAST_ROW)
      else $error("scroll away from bottom row");

   // tab expansion counter only runs for a tab put
   a_tab_count_tab: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && seq_ff.tab_count != 2'd0) |->
         (cmd_ff.opcode == OP_PUT && cmd_ff.char_code == CHAR_TAB))
      else $error("tab counter active outside a tab");

   // a finished command releases the slot: the next cycle is idle or a new item
   a_done_release: assert property (@(posedge clock) disable iff (reset)
      (fire && step.done && !accept) |=> !busy_ff)
      else $error("engine stayed busy after last item");

endmodule
